>>> design/imuseq_pkg.sv
// Shared types, codes and the register table of the IMU bring-up and poll sequencer.
package imuseq_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 7;
  localparam int unsigned NUM_WORDS = 7;

  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd10;
  localparam logic [15:0] STALE_LIMIT_RST   = 16'd500;
  localparam logic [15:0] RETRY_PERIOD_RST  = 16'd1000;

  localparam logic [31:0] POWER_WAIT_MS = 32'd100;
  localparam logic [31:0] SETTLE_MS     = 32'd50;

  localparam logic [7:0] WHO_AM_I_ADDR = 8'h75;
  localparam logic [7:0] WHO_AM_I_VAL  = 8'h68;
  localparam logic [7:0] PWR_MGMT_ADDR = 8'h6B;
  localparam logic [7:0] RESET_VAL     = 8'h80;
  localparam logic [7:0] BURST_ADDR    = 8'h3A;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_STALE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_RETRY_PERIOD  = 2'd2;

  typedef enum logic [2:0] {
    PH_POWER_WAIT = 3'd0,
    PH_PROBE      = 3'd1,
    PH_RESET      = 3'd2,
    PH_RESET_WAIT = 3'd3,
    PH_CONFIGURE  = 3'd4,
    PH_SAMPLE     = 3'd5,
    PH_RETRY      = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_STARTING   = 3'd0,
    ST_READY      = 3'd1,
    ST_BUS_ERROR  = 3'd2,
    ST_ID_ERROR   = 3'd3,
    ST_DATA_ERROR = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_ID    = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_BURST = 2'd3
  } req_t;

  typedef struct packed {
    logic [31:0]                now;
    logic                       bus_ok;
    logic [7:0]                 read_byte;
    logic [NUM_WORDS-1:0][15:0] words;
  } item_t;

  typedef struct packed {
    logic [1:0]                 request_kind;
    logic [7:0]                 reg_addr;
    logic [7:0]                 reg_value;
    logic [2:0]                 sensor_status;
    logic                       sample_fresh;
    logic [NUM_WORDS-1:0][15:0] words;
  } result_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
  } tbl_entry_t;

  function automatic tbl_entry_t init_table(input logic [2:0] idx);
    tbl_entry_t e;
    case (idx)
      3'd0:    e = '{addr: 8'h6B, value: 8'h01};
      3'd1:    e = '{addr: 8'h6C, value: 8'h00};
      3'd2:    e = '{addr: 8'h1A, value: 8'h03};
      3'd3:    e = '{addr: 8'h19, value: 8'h09};
      3'd4:    e = '{addr: 8'h1B, value: 8'h00};
      3'd5:    e = '{addr: 8'h1C, value: 8'h00};
      default: e = '{addr: 8'h38, value: 8'h01};
    endcase
    return e;
  endfunction

endpackage

>>> design/imuseq_ctrl.sv
// Phase state machine and sample store; decides one tick per transfer.
module imuseq_ctrl
  import imuseq_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] sample_period,
  input  logic [15:0] stale_limit,
  input  logic [15:0] retry_period,
  output result_t     res
);

  localparam int unsigned STEP_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_ENTRIES - 1);

  phase_t                     phase_r, phase_nxt;
  status_t                    status_r, status_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [31:0]                start_r, start_nxt;
  logic [31:0]                poll_r, poll_nxt;
  logic [31:0]                data_r, data_nxt;
  logic [31:0]                stime_r, stime_nxt;
  logic                       held_r, held_nxt;
  logic [NUM_WORDS-1:0][15:0] words_r, words_nxt;

  logic [31:0] since_start, since_poll, since_data, age;
  tbl_entry_t  entry;

  assign since_start = item.now - start_r;
  assign since_poll  = item.now - poll_r;
  assign since_data  = item.now - data_r;
  assign entry       = init_table(3'(step_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_POWER_WAIT;
      status_r <= ST_STARTING;
      step_r   <= '0;
      start_r  <= '0;
      poll_r   <= '0;
      data_r   <= '0;
      stime_r  <= '0;
      held_r   <= 1'b0;
      words_r  <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      step_r   <= step_nxt;
      start_r  <= start_nxt;
      poll_r   <= poll_nxt;
      data_r   <= data_nxt;
      stime_r  <= stime_nxt;
      held_r   <= held_nxt;
      words_r  <= words_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    step_nxt   = step_r;
    start_nxt  = start_r;
    poll_nxt   = poll_r;
    data_nxt   = data_r;
    stime_nxt  = stime_r;
    held_nxt   = held_r;
    words_nxt  = words_r;
    res.request_kind = REQ_NONE;
    res.reg_addr     = '0;
    res.reg_value    = '0;
    unique case (phase_r)
      PH_POWER_WAIT, PH_RESET_WAIT: begin
        if (since_start >= POWER_WAIT_MS) begin
          phase_nxt = (phase_r == PH_POWER_WAIT) ? PH_PROBE : PH_CONFIGURE;
        end
      end
      PH_PROBE: begin
        res.request_kind = REQ_ID;
        res.reg_addr     = WHO_AM_I_ADDR;
        if (!item.bus_ok) begin
          status_nxt = ST_BUS_ERROR;
          held_nxt   = 1'b0;
          phase_nxt  = PH_RETRY;
          start_nxt  = item.now;
        end else if (item.read_byte != WHO_AM_I_VAL) begin
          status_nxt = ST_ID_ERROR;
          held_nxt   = 1'b0;
          phase_nxt  = PH_RETRY;
          start_nxt  = item.now;
        end else begin
          phase_nxt = PH_RESET;
        end
      end
      PH_RESET: begin
        res.request_kind = REQ_WRITE;
        res.reg_addr     = PWR_MGMT_ADDR;
        res.reg_value    = RESET_VAL;
        start_nxt        = item.now;
        if (!item.bus_ok) begin
          status_nxt = ST_BUS_ERROR;
          held_nxt   = 1'b0;
          phase_nxt  = PH_RETRY;
        end else begin
          phase_nxt = PH_RESET_WAIT;
          step_nxt  = '0;
        end
      end
      PH_CONFIGURE: begin
        // The clock-source write needs time to settle before the second entry.
        if (!(step_r == STEP_W'(1) && since_start < SETTLE_MS)) begin
          res.request_kind = REQ_WRITE;
          res.reg_addr     = entry.addr;
          res.reg_value    = entry.value;
          start_nxt        = item.now;
          if (!item.bus_ok) begin
            status_nxt = ST_BUS_ERROR;
            held_nxt   = 1'b0;
            phase_nxt  = PH_RETRY;
          end else if (step_r == LAST_STEP) begin
            step_nxt  = '0;
            phase_nxt = PH_SAMPLE;
            poll_nxt  = item.now;
            data_nxt  = item.now;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      PH_SAMPLE: begin
        if (since_poll >= 32'(sample_period)) begin
          poll_nxt         = item.now;
          res.request_kind = REQ_BURST;
          res.reg_addr     = BURST_ADDR;
          if (!item.bus_ok) begin
            status_nxt = ST_BUS_ERROR;
            held_nxt   = 1'b0;
            phase_nxt  = PH_RETRY;
            start_nxt  = item.now;
          end else if (!item.read_byte[0]) begin
            if (since_data >= 32'(stale_limit)) begin
              status_nxt = ST_DATA_ERROR;
              held_nxt   = 1'b0;
              phase_nxt  = PH_RETRY;
              start_nxt  = item.now;
            end
          end else begin
            words_nxt  = item.words;
            stime_nxt  = item.now;
            data_nxt   = item.now;
            held_nxt   = 1'b1;
            status_nxt = ST_READY;
          end
        end
      end
      default: begin
        phase_nxt = PH_RETRY;
        if (since_start >= 32'(retry_period)) begin
          status_nxt = ST_STARTING;
          phase_nxt  = PH_PROBE;
        end
      end
    endcase
    age = item.now - stime_nxt;
    res.sensor_status = status_nxt;
    res.sample_fresh  = (status_nxt == ST_READY) && held_nxt && (age < 32'(stale_limit));
    res.words         = words_nxt;
  end

  a_ready_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == ST_READY |-> held_r)
    else $error("ready status without a held sample");

  a_error_in_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_BUS_ERROR || status_r == ST_ID_ERROR || status_r == ST_DATA_ERROR)
    |-> phase_r == PH_RETRY)
    else $error("error status outside the retry phase");

  a_reset_ok_waits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_RESET && item.bus_ok |=> phase_r == PH_RESET_WAIT)
    else $error("soft reset accepted but reset wait not entered");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(status_r) && $stable(step_r))
    else $error("state moved without a transfer");

endmodule

>>> design/imu_sensor_bringup_poll_sequencer.sv
// Sequencer core: one transfer in is one millisecond tick with the outcome of that tick's
// bus transaction; one result comes out per tick, naming the transaction to perform
// together with the status, freshness flag and latest sample. Every tick passes through a
// single decision stage between an input register and an output register, so a transfer
// can be accepted every cycle while out_stall is low; the input register keeps taking one
// transfer while a result waits on out_stall. The result is registered in the output
// register when the decision stage fires on the transfer held in the input register.
// Configuration registers (byte addresses 0, 4, 8: sample period, stale limit, retry
// period, 16 bits each) should be written only while no tick is in flight.
module imu_sensor_bringup_poll_sequencer
  import imuseq_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_now,
  input  logic               in_bus_ok,
  input  logic [7:0]         in_read_byte,
  input  logic [15:0]        in_accel_x_raw,
  input  logic [15:0]        in_accel_y_raw,
  input  logic [15:0]        in_accel_z_raw,
  input  logic [15:0]        in_temp_raw,
  input  logic [15:0]        in_gyro_x_raw,
  input  logic [15:0]        in_gyro_y_raw,
  input  logic [15:0]        in_gyro_z_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_request_kind,
  output logic [7:0]         out_reg_addr,
  output logic [7:0]         out_reg_value,
  output logic [2:0]         out_sensor_status,
  output logic               out_sample_fresh,
  output logic signed [15:0] out_accel_x_out,
  output logic signed [15:0] out_accel_y_out,
  output logic signed [15:0] out_accel_z_out,
  output logic signed [15:0] out_temp_out,
  output logic signed [15:0] out_gyro_x_out,
  output logic signed [15:0] out_gyro_y_out,
  output logic signed [15:0] out_gyro_z_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        in_valid_r;
  item_t       item_r;
  logic        out_valid_r;
  result_t     res_r, res;
  logic        fire;
  logic [15:0] period_r, stale_r, retry_r;
  logic        cfg_wr;

  // The decision stage advances when the output register is free or being emptied.
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.now       <= in_now;
      item_r.bus_ok    <= in_bus_ok;
      item_r.read_byte <= in_read_byte;
      item_r.words     <= {in_gyro_z_raw, in_gyro_y_raw, in_gyro_x_raw, in_temp_raw,
                           in_accel_z_raw, in_accel_y_raw, in_accel_x_raw};
    end
  end

  imuseq_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (item_r),
    .sample_period(period_r),
    .stale_limit  (stale_r),
    .retry_period (retry_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_request_kind  = res_r.request_kind;
  assign out_reg_addr      = res_r.reg_addr;
  assign out_reg_value     = res_r.reg_value;
  assign out_sensor_status = res_r.sensor_status;
  assign out_sample_fresh  = res_r.sample_fresh;
  assign out_accel_x_out   = res_r.words[0];
  assign out_accel_y_out   = res_r.words[1];
  assign out_accel_z_out   = res_r.words[2];
  assign out_temp_out      = res_r.words[3];
  assign out_gyro_x_out    = res_r.words[4];
  assign out_gyro_y_out    = res_r.words[5];
  assign out_gyro_z_out    = res_r.words[6];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= SAMPLE_PERIOD_RST;
      stale_r  <= STALE_LIMIT_RST;
      retry_r  <= RETRY_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SAMPLE_PERIOD: period_r <= pwdata[15:0];
        REG_STALE_LIMIT:   stale_r  <= pwdata[15:0];
        REG_RETRY_PERIOD:  retry_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SAMPLE_PERIOD: prdata = {16'd0, period_r};
      REG_STALE_LIMIT:   prdata = {16'd0, stale_r};
      REG_RETRY_PERIOD:  prdata = {16'd0, retry_r};
      default:           prdata = '0;
    endcase
  end

endmodule
